// ===== rtl/lay_pkg.sv =====
// lay_pkg.sv: shared widths, angle constants, the arctangent table and the
// output saturation helper of the look-at yaw quaternion block.
// No dependencies.
`timescale 1ns / 1ps

package lay_pkg;

    // Field widths
    localparam int POS_W      = 32;
    localparam int QUAT_W     = 16;
    localparam int IN_DATA_W  = 4 * POS_W;
    localparam int OUT_DATA_W = 4 * QUAT_W;

    // Default number of CORDIC micro-rotations in each direction
    localparam int ANGLE_ITERATIONS_DEF = 16;

    // Internal CORDIC widths: x/y carry the grown vector, z is a Q30 angle
    localparam int XY_W  = 40;
    localparam int ANG_W = 36;

    // Quotient width of the normalizing divide
    localparam int Q2_W = 18;

    typedef logic signed [XY_W-1:0]  cxy_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    localparam ang_t PI_Q30       = 36'sd3373259426;
    localparam ang_t HALF_PI_Q30  = 36'sd1686629713;
    localparam cxy_t INV_GAIN_Q30 = 40'sd652032874;
    localparam logic signed [POS_W-1:0] ONE_Q30 = 32'sd1073741824;

    // atan(2^-i) in Q30
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    // Apply a sign to a quotient magnitude and saturate to Q1.14.
    function automatic logic signed [QUAT_W-1:0] sat_q14(input logic neg,
                                                         input logic [Q2_W-1:0] mag);
        logic signed [Q2_W+1:0] v;
        v = signed'({2'b00, mag});
        if (neg)
            v = -v;
        if (v > (Q2_W+2)'(32767))
            return 16'sh7FFF;
        if (v < -(Q2_W+2)'(32768))
            return 16'sh8000;
        return v[QUAT_W-1:0];
    endfunction

endpackage

// ===== rtl/lay_cordic_cell.sv =====
// lay_cordic_cell.sv: one registered CORDIC micro-rotation, in vectoring or
// rotation mode, passing a sideband word along. Depends on lay_pkg.
`timescale 1ns / 1ps

module lay_cordic_cell #(
    parameter int XW     = lay_pkg::XY_W,
    parameter int ZW     = lay_pkg::ANG_W,
    parameter int SW     = 1,
    parameter int I      = 0,
    parameter bit VECTOR = 1'b1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid,
    input  logic signed [XW-1:0] x,
    input  logic signed [XW-1:0] y,
    input  logic signed [ZW-1:0] z,
    input  logic [SW-1:0]        side,
    output logic                 fwd_valid,
    output logic signed [XW-1:0] fwd_x,
    output logic signed [XW-1:0] fwd_y,
    output logic signed [ZW-1:0] fwd_z,
    output logic [SW-1:0]        fwd_side
);
    import lay_pkg::*;

    localparam logic signed [ZW-1:0] ATAN_I = signed'(ZW'(ATAN_TAB[I[4:0]]));

    logic                 valid_reg;
    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next, x_sh, y_sh;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [SW-1:0]        side_reg;
    logic                 ccw;

    // Direction: vectoring drives y to zero, rotation drives z to zero.
    assign x_sh = x >>> I;
    assign y_sh = y >>> I;
    assign ccw  = VECTOR ? y[XW-1] : !z[ZW-1];

    always_comb
    begin
        if (ccw)
        begin
            x_next = x - y_sh;
            y_next = y + x_sh;
            z_next = z - ATAN_I;
        end
        else
        begin
            x_next = x + y_sh;
            y_next = y - x_sh;
            z_next = z + ATAN_I;
        end
    end

    // Item valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid;
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side;
        end
    end

    assign fwd_valid = valid_reg;
    assign fwd_x     = x_reg;
    assign fwd_y     = y_reg;
    assign fwd_z     = z_reg;
    assign fwd_side  = side_reg;

endmodule

// ===== rtl/lay_sqrt_cell.sv =====
// lay_sqrt_cell.sv: one registered digit of a restoring integer square root,
// deciding result bit K. No package dependency.
`timescale 1ns / 1ps

module lay_sqrt_cell #(
    parameter int VW = 62,
    parameter int K  = 30,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid,
    input  logic [VW-1:0]   rem,
    input  logic [VW/2-1:0] root,
    input  logic [SW-1:0]   side,
    output logic            fwd_valid,
    output logic [VW-1:0]   fwd_rem,
    output logic [VW/2-1:0] fwd_root,
    output logic [SW-1:0]   fwd_side
);
    localparam int RW = VW / 2;

    logic            valid_reg;
    logic [VW-1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [SW-1:0]   side_reg;
    logic [VW:0]     trial;
    logic            take;

    // Setting bit K grows root^2 by (2*root + 2^K) * 2^K.
    assign trial = ({{(RW+1){1'b0}}, root} << (K + 1)) | ((VW+1)'(1) << (2 * K));
    assign take  = {1'b0, rem} >= trial;
    assign rem_next  = take ? rem - trial[VW-1:0] : rem;
    assign root_next = take ? (root | (RW'(1) << K)) : root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side;
        end
    end

    assign fwd_valid = valid_reg;
    assign fwd_rem   = rem_reg;
    assign fwd_root  = root_reg;
    assign fwd_side  = side_reg;

endmodule

// ===== rtl/lay_div_cell.sv =====
// lay_div_cell.sv: one registered quotient bit of a restoring divider, for
// several numerators that share one divisor. No package dependency.
`timescale 1ns / 1ps

module lay_div_cell #(
    parameter int NW    = 62,
    parameter int DW    = 32,
    parameter int QW    = 32,
    parameter int K     = 31,
    parameter int LANES = 2,
    parameter int SW    = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid,
    input  logic [DW-1:0] den,
    input  logic [NW-1:0] rem [LANES],
    input  logic [QW-1:0] quo [LANES],
    input  logic [SW-1:0] side,
    output logic          fwd_valid,
    output logic [DW-1:0] fwd_den,
    output logic [NW-1:0] fwd_rem [LANES],
    output logic [QW-1:0] fwd_quo [LANES],
    output logic [SW-1:0] fwd_side
);
    logic             valid_reg;
    logic [DW-1:0]    den_reg;
    logic [NW-1:0]    rem_reg [LANES];
    logic [NW-1:0]    rem_next [LANES];
    logic [QW-1:0]    quo_reg [LANES];
    logic [QW-1:0]    quo_next [LANES];
    logic [SW-1:0]    side_reg;
    logic [LANES-1:0] take;

    // Subtract den * 2^K from each lane where it fits.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            take[l]     = (rem[l] >> K) >= NW'(den);
            rem_next[l] = take[l] ? rem[l] - (NW'(den) << K) : rem[l];
            quo_next[l] = take[l] ? (quo[l] | (QW'(1) << K)) : quo[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= den;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            side_reg <= side;
        end
    end

    assign fwd_valid = valid_reg;
    assign fwd_den   = den_reg;
    assign fwd_rem   = rem_reg;
    assign fwd_quo   = quo_reg;
    assign fwd_side  = side_reg;

endmodule

// ===== rtl/look_at_yaw_quaternion.sv =====
// look_at_yaw_quaternion: camera quaternion that looks from a tracker to a target.
// The datapath is the two CORDIC chains, the 31- and 32-stage root chains and the
// 32- and 18-stage divider chains; one item per cycle is accepted and delivered
// while the output is not stalled with another finished item waiting behind it.
// rst_n clears only the valid flags; uses lay_pkg and the lay_*_cell modules.
`timescale 1ns / 1ps

module look_at_yaw_quaternion #(
    parameter int ANGLE_ITERATIONS = lay_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tracker_x, tracker_y, target_x, target_y (lowest bits first)
    input  logic [lay_pkg::IN_DATA_W-1:0]  s_tdata,
    // target_valid
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // quat_x, quat_y, quat_z, quat_w (lowest bits first)
    output logic [lay_pkg::OUT_DATA_W-1:0] m_tdata
);
    import lay_pkg::*;

    localparam int N     = ANGLE_ITERATIONS;
    localparam int V1_W  = 62;
    localparam int R1_W  = V1_W / 2;
    localparam int S1_W  = 1 + 2 * POS_W;
    localparam int D1_NW = 62;
    localparam int D1_QW = 32;
    localparam int D1_SW = 2 + R1_W;
    localparam int H_W   = R1_W - 1;
    localparam int V2_W  = 64;
    localparam int R2_W  = V2_W / 2;
    localparam int S2_W  = 2 + 2 * D1_QW + H_W;
    localparam int D2_NW = 48;

    // Clamp a CORDIC result to [-1.0, 1.0] in Q30.
    function automatic logic signed [POS_W-1:0] clamp_unit(input cxy_t v);
        cxy_t one_w;
        one_w = XY_W'(ONE_Q30);
        if (v > one_w)
            return ONE_Q30;
        if (v < -one_w)
            return -ONE_Q30;
        return v[POS_W-1:0];
    endfunction

    // Pipeline advance: stop only when the output holds an untaken item and another waits.
    logic en, last_valid;
    logic out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign en       = !out_valid_reg || m_tready || !last_valid;
    assign s_tready = en;

    // Input stage: differences, special cases and half-plane fold.
    logic signed [POS_W-1:0] trk_x, trk_y, tgt_x, tgt_y;
    logic signed [POS_W:0]   dx, dy;
    logic                    in_valid_reg, in_special_reg;
    cxy_t                    in_x_reg, in_y_reg;
    ang_t                    in_z_reg;

    assign trk_x = s_tdata[POS_W-1:0];
    assign trk_y = s_tdata[2*POS_W-1:POS_W];
    assign tgt_x = s_tdata[3*POS_W-1:2*POS_W];
    assign tgt_y = s_tdata[4*POS_W-1:3*POS_W];
    assign dx = (POS_W+1)'(tgt_x) - (POS_W+1)'(trk_x);
    assign dy = (POS_W+1)'(tgt_y) - (POS_W+1)'(trk_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (en)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_special_reg <= !s_tuser || (dx == '0 && dy == '0);
            if (dx[POS_W])
            begin
                in_x_reg <= -XY_W'(dx);
                in_y_reg <= -XY_W'(dy);
                in_z_reg <= dy[POS_W] ? -PI_Q30 : PI_Q30;
            end
            else
            begin
                in_x_reg <= XY_W'(dx);
                in_y_reg <= XY_W'(dy);
                in_z_reg <= '0;
            end
        end
    end

    // Vectoring chain: angle of (dx, dy).
    cxy_t       vx [N+1];
    cxy_t       vy [N+1];
    ang_t       vz [N+1];
    logic       vv [N+1];
    logic [0:0] vs [N+1];

    assign vx[0] = in_x_reg;
    assign vy[0] = in_y_reg;
    assign vz[0] = in_z_reg;
    assign vv[0] = in_valid_reg;
    assign vs[0] = in_special_reg;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_vec
            lay_cordic_cell #(.XW(XY_W), .ZW(ANG_W), .SW(1), .I(gi), .VECTOR(1'b1)) u_cordic (
                .clk(clk), .rst_n(rst_n), .en(en),
                .valid(vv[gi]), .x(vx[gi]), .y(vy[gi]), .z(vz[gi]), .side(vs[gi]),
                .fwd_valid(vv[gi+1]), .fwd_x(vx[gi+1]), .fwd_y(vy[gi+1]),
                .fwd_z(vz[gi+1]), .fwd_side(vs[gi+1])
            );
        end
    endgenerate

    // Fold stage: bring the angle into a quarter turn either side of zero.
    logic fd_valid_reg, fd_flip_reg, fd_special_reg;
    ang_t fd_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fd_valid_reg <= 1'b0;
        else if (en)
            fd_valid_reg <= vv[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fd_special_reg <= vs[N][0];
            if (vz[N] > HALF_PI_Q30)
            begin
                fd_z_reg    <= vz[N] - PI_Q30;
                fd_flip_reg <= 1'b1;
            end
            else if (vz[N] < -HALF_PI_Q30)
            begin
                fd_z_reg    <= vz[N] + PI_Q30;
                fd_flip_reg <= 1'b1;
            end
            else
            begin
                fd_z_reg    <= vz[N];
                fd_flip_reg <= 1'b0;
            end
        end
    end

    // Rotation chain: cos and sin of the angle.
    cxy_t       rx [N+1];
    cxy_t       ry [N+1];
    ang_t       rz [N+1];
    logic       rv [N+1];
    logic [1:0] rs [N+1];

    assign rx[0] = INV_GAIN_Q30;
    assign ry[0] = '0;
    assign rz[0] = fd_z_reg;
    assign rv[0] = fd_valid_reg;
    assign rs[0] = {fd_special_reg, fd_flip_reg};

    generate
        for (gi = 0; gi < N; gi++)
        begin : g_rot
            lay_cordic_cell #(.XW(XY_W), .ZW(ANG_W), .SW(2), .I(gi), .VECTOR(1'b0)) u_cordic (
                .clk(clk), .rst_n(rst_n), .en(en),
                .valid(rv[gi]), .x(rx[gi]), .y(ry[gi]), .z(rz[gi]), .side(rs[gi]),
                .fwd_valid(rv[gi+1]), .fwd_x(rx[gi+1]), .fwd_y(ry[gi+1]),
                .fwd_z(rz[gi+1]), .fwd_side(rs[gi+1])
            );
        end
    endgenerate

    // Sin/cos stage: undo the fold, clamp, and force the special cases.
    logic                    sc_valid_reg;
    logic signed [POS_W-1:0] sc_sn_reg, sc_cs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_valid_reg <= 1'b0;
        else if (en)
            sc_valid_reg <= rv[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rs[N][1])
            begin
                sc_sn_reg <= '0;
                sc_cs_reg <= ONE_Q30;
            end
            else if (rs[N][0])
            begin
                sc_sn_reg <= clamp_unit(-ry[N]);
                sc_cs_reg <= clamp_unit(-rx[N]);
            end
            else
            begin
                sc_sn_reg <= clamp_unit(ry[N]);
                sc_cs_reg <= clamp_unit(rx[N]);
            end
        end
    end

    // Trace stage: t = 1 + |sin|, the root argument of either branch.
    logic                    tr_valid_reg, tr_snpos_reg;
    logic [POS_W-1:0]        tr_t_reg;
    logic signed [POS_W-1:0] tr_cs_reg;
    logic signed [POS_W-1:0] sn_abs;

    assign sn_abs = sc_sn_reg[POS_W-1] ? -sc_sn_reg : sc_sn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tr_valid_reg <= 1'b0;
        else if (en)
            tr_valid_reg <= sc_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tr_t_reg     <= unsigned'(ONE_Q30) + unsigned'(sn_abs);
            tr_cs_reg    <= sc_cs_reg;
            tr_snpos_reg <= !sc_sn_reg[POS_W-1] && (sc_sn_reg != '0);
        end
    end

    // First root chain: r = floor sqrt(t * 2^30), so s = 2r.
    logic [V1_W-1:0] q1rem  [R1_W+1];
    logic [R1_W-1:0] q1root [R1_W+1];
    logic            q1v    [R1_W+1];
    logic [S1_W-1:0] q1s    [R1_W+1];

    assign q1rem[0]  = {tr_t_reg, 30'b0};
    assign q1root[0] = '0;
    assign q1v[0]    = tr_valid_reg;
    assign q1s[0]    = {tr_snpos_reg, tr_cs_reg, tr_t_reg};

    generate
        for (gi = 0; gi < R1_W; gi++)
        begin : g_sq1
            lay_sqrt_cell #(.VW(V1_W), .K(R1_W - 1 - gi), .SW(S1_W)) u_sqrt (
                .clk(clk), .rst_n(rst_n), .en(en),
                .valid(q1v[gi]), .rem(q1rem[gi]), .root(q1root[gi]), .side(q1s[gi]),
                .fwd_valid(q1v[gi+1]), .fwd_rem(q1rem[gi+1]), .fwd_root(q1root[gi+1]),
                .fwd_side(q1s[gi+1])
            );
        end
    endgenerate

    // Divide setup: rounded numerators t*2^30 + r and |cos|*2^30 + r over s.
    logic                    pd_valid_reg;
    logic [D1_NW-1:0]        pd_num_a_reg, pd_num_c_reg;
    logic [D1_QW-1:0]        pd_den_reg;
    logic [D1_SW-1:0]        pd_side_reg;
    logic signed [POS_W-1:0] p_cs;
    logic [POS_W-1:0]        p_cs_abs;

    assign p_cs     = q1s[R1_W][2*POS_W-1:POS_W];
    assign p_cs_abs = p_cs[POS_W-1] ? unsigned'(-p_cs) : unsigned'(p_cs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pd_valid_reg <= 1'b0;
        else if (en)
            pd_valid_reg <= q1v[R1_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd_num_a_reg <= {q1s[R1_W][POS_W-1:0], 30'b0} + D1_NW'(q1root[R1_W]);
            pd_num_c_reg <= {p_cs_abs, 30'b0} + D1_NW'(q1root[R1_W]);
            pd_den_reg   <= {q1root[R1_W], 1'b0};
            pd_side_reg  <= {q1s[R1_W][S1_W-1], p_cs[POS_W-1], q1root[R1_W]};
        end
    end

    // First divider chain: A = t*2^30 / s and C = |cos|*2^30 / s.
    logic [D1_NW-1:0] d1rem [D1_QW+1][2];
    logic [D1_QW-1:0] d1quo [D1_QW+1][2];
    logic [D1_QW-1:0] d1den [D1_QW+1];
    logic             d1v   [D1_QW+1];
    logic [D1_SW-1:0] d1s   [D1_QW+1];

    assign d1rem[0][0] = pd_num_a_reg;
    assign d1rem[0][1] = pd_num_c_reg;
    assign d1quo[0][0] = '0;
    assign d1quo[0][1] = '0;
    assign d1den[0]    = pd_den_reg;
    assign d1v[0]      = pd_valid_reg;
    assign d1s[0]      = pd_side_reg;

    generate
        for (gi = 0; gi < D1_QW; gi++)
        begin : g_div1
            lay_div_cell #(.NW(D1_NW), .DW(D1_QW), .QW(D1_QW), .K(D1_QW - 1 - gi),
                           .LANES(2), .SW(D1_SW)) u_div (
                .clk(clk), .rst_n(rst_n), .en(en),
                .valid(d1v[gi]), .den(d1den[gi]), .rem(d1rem[gi]), .quo(d1quo[gi]),
                .side(d1s[gi]),
                .fwd_valid(d1v[gi+1]), .fwd_den(d1den[gi+1]), .fwd_rem(d1rem[gi+1]),
                .fwd_quo(d1quo[gi+1]), .fwd_side(d1s[gi+1])
            );
        end
    endgenerate

    // Square stage: A^2, C^2 and H^2 with H = s/4 = r/2.
    logic             sq_valid_reg, sq_snpos_reg, sq_csneg_reg;
    logic [63:0]      sq_a2_reg, sq_c2_reg;
    logic [2*H_W-1:0] sq_h2_reg;
    logic [D1_QW-1:0] sq_qa_reg, sq_qc_reg;
    logic [H_W-1:0]   sq_h_reg;
    logic [H_W-1:0]   h_val;

    assign h_val = d1s[D1_QW][R1_W-1:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg <= 1'b0;
        else if (en)
            sq_valid_reg <= d1v[D1_QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_a2_reg    <= d1quo[D1_QW][0] * d1quo[D1_QW][0];
            sq_c2_reg    <= d1quo[D1_QW][1] * d1quo[D1_QW][1];
            sq_h2_reg    <= h_val * h_val;
            sq_qa_reg    <= d1quo[D1_QW][0];
            sq_qc_reg    <= d1quo[D1_QW][1];
            sq_h_reg     <= h_val;
            sq_snpos_reg <= d1s[D1_QW][D1_SW-1];
            sq_csneg_reg <= d1s[D1_QW][D1_SW-2];
        end
    end

    // Sum stages: A^2 + H^2 and 2*C^2, then the full sum of squares.
    logic             ad1_valid_reg, ad2_valid_reg;
    logic [63:0]      ad1_sa_reg, ad1_sc_reg, ad2_sum_reg;
    logic [S2_W-1:0]  ad1_side_reg, ad2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ad1_valid_reg <= 1'b0;
            ad2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ad1_valid_reg <= sq_valid_reg;
            ad2_valid_reg <= ad1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ad1_sa_reg   <= sq_a2_reg + 64'(sq_h2_reg);
            ad1_sc_reg   <= {sq_c2_reg[62:0], 1'b0};
            ad1_side_reg <= {sq_snpos_reg, sq_csneg_reg, sq_qa_reg, sq_qc_reg, sq_h_reg};
            ad2_sum_reg  <= ad1_sa_reg + ad1_sc_reg;
            ad2_side_reg <= ad1_side_reg;
        end
    end

    // Second root chain: the quaternion norm in Q30.
    logic [V2_W-1:0] q2rem  [R2_W+1];
    logic [R2_W-1:0] q2root [R2_W+1];
    logic            q2v    [R2_W+1];
    logic [S2_W-1:0] q2s    [R2_W+1];

    assign q2rem[0]  = ad2_sum_reg;
    assign q2root[0] = '0;
    assign q2v[0]    = ad2_valid_reg;
    assign q2s[0]    = ad2_side_reg;

    generate
        for (gi = 0; gi < R2_W; gi++)
        begin : g_sq2
            lay_sqrt_cell #(.VW(V2_W), .K(R2_W - 1 - gi), .SW(S2_W)) u_sqrt (
                .clk(clk), .rst_n(rst_n), .en(en),
                .valid(q2v[gi]), .rem(q2rem[gi]), .root(q2root[gi]), .side(q2s[gi]),
                .fwd_valid(q2v[gi+1]), .fwd_rem(q2rem[gi+1]), .fwd_root(q2root[gi+1]),
                .fwd_side(q2s[gi+1])
            );
        end
    endgenerate

    // Normalize setup: rounded numerators part*2^14 + norm/2 over the norm.
    logic             pn_valid_reg;
    logic [D2_NW-1:0] pn_num_reg [3];
    logic [R2_W-1:0]  pn_den_reg;
    logic [1:0]       pn_side_reg;
    logic [D2_NW-1:0] half_norm;
    logic [D1_QW-1:0] n_qa, n_qc;
    logic [H_W-1:0]   n_h;

    assign half_norm = D2_NW'(q2root[R2_W] >> 1);
    assign n_qa = q2s[R2_W][2*D1_QW+H_W-1:D1_QW+H_W];
    assign n_qc = q2s[R2_W][D1_QW+H_W-1:H_W];
    assign n_h  = q2s[R2_W][H_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pn_valid_reg <= 1'b0;
        else if (en)
            pn_valid_reg <= q2v[R2_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pn_num_reg[0] <= D2_NW'({n_qa, 14'b0}) + half_norm;
            pn_num_reg[1] <= D2_NW'({n_qc, 14'b0}) + half_norm;
            pn_num_reg[2] <= D2_NW'({n_h, 14'b0}) + half_norm;
            pn_den_reg    <= q2root[R2_W];
            pn_side_reg   <= q2s[R2_W][S2_W-1:S2_W-2];
        end
    end

    // Second divider chain: the three magnitudes over the norm.
    logic [D2_NW-1:0] d2rem [Q2_W+1][3];
    logic [Q2_W-1:0]  d2quo [Q2_W+1][3];
    logic [R2_W-1:0]  d2den [Q2_W+1];
    logic             d2v   [Q2_W+1];
    logic [1:0]       d2s   [Q2_W+1];

    assign d2rem[0] = pn_num_reg;
    assign d2quo[0][0] = '0;
    assign d2quo[0][1] = '0;
    assign d2quo[0][2] = '0;
    assign d2den[0] = pn_den_reg;
    assign d2v[0]   = pn_valid_reg;
    assign d2s[0]   = pn_side_reg;

    generate
        for (gi = 0; gi < Q2_W; gi++)
        begin : g_div2
            lay_div_cell #(.NW(D2_NW), .DW(R2_W), .QW(Q2_W), .K(Q2_W - 1 - gi),
                           .LANES(3), .SW(2)) u_div (
                .clk(clk), .rst_n(rst_n), .en(en),
                .valid(d2v[gi]), .den(d2den[gi]), .rem(d2rem[gi]), .quo(d2quo[gi]),
                .side(d2s[gi]),
                .fwd_valid(d2v[gi+1]), .fwd_den(d2den[gi+1]), .fwd_rem(d2rem[gi+1]),
                .fwd_quo(d2quo[gi+1]), .fwd_side(d2s[gi+1])
            );
        end
    endgenerate

    // Output register: place signs by branch and saturate to Q1.14.
    logic                     o_snpos, o_csneg;
    logic signed [QUAT_W-1:0] o_x, o_y, o_z, o_w;

    assign last_valid = d2v[Q2_W];
    assign o_snpos    = d2s[Q2_W][1];
    assign o_csneg    = d2s[Q2_W][0];

    always_comb
    begin
        if (o_snpos)
        begin
            o_x = sat_q14(1'b1, d2quo[Q2_W][0]);
            o_y = sat_q14(o_csneg, d2quo[Q2_W][1]);
            o_z = sat_q14(!o_csneg, d2quo[Q2_W][1]);
            o_w = sat_q14(1'b0, d2quo[Q2_W][2]);
        end
        else
        begin
            o_x = sat_q14(o_csneg, d2quo[Q2_W][1]);
            o_y = sat_q14(1'b1, d2quo[Q2_W][0]);
            o_z = sat_q14(1'b0, d2quo[Q2_W][2]);
            o_w = sat_q14(!o_csneg, d2quo[Q2_W][1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || m_tready)
            out_valid_reg <= last_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
            out_data_reg <= {o_w, o_z, o_y, o_x};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A stalled output keeps the finished item behind it in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && last_valid) |=> last_valid)
        else $error("item behind a stalled output was lost");

    // sqrt(t * 2^30) with t in [1.0, 2.0] always lies in [2^30, 2^31).
    assert property (@(posedge clk) disable iff (!rst_n)
        q1v[R1_W] |-> q1root[R1_W][R1_W-1])
        else $error("trace root out of range");

    // The norm is never below one half, since the quarter term is at least that.
    assert property (@(posedge clk) disable iff (!rst_n)
        q2v[R2_W] |-> (q2root[R2_W][R2_W-1:R2_W-3] != '0))
        else $error("quaternion norm below one half");

endmodule

// ===== sim/tb.sv =====
// tb.sv: self-checking testbench for look_at_yaw_quaternion.
// Drives tracker and target positions over the input stream, predicts each camera
// quaternion in fixed point and compares it field by field; uses lay_pkg.
`timescale 1ns / 1ps

module tb;

    import lay_pkg::*;

    localparam int  ITERS      = ANGLE_ITERATIONS_DEF;
    localparam int  RAND_ITEMS = 1430;
    localparam int  IDLE_LIMIT = 5000;
    localparam int  DRAIN      = 300;
    localparam longint ONE     = 64'sd1073741824;
    localparam longint PI_V    = 64'sd3373259426;
    localparam longint HPI_V   = 64'sd1686629713;
    localparam longint IGAIN   = 64'sd652032874;

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] z;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] x;
    } quat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    quat_t  quat_expected[$];
    int     mismatches;
    int     items_sent;
    int     quats_checked;
    int     idle_cycles;
    bit     no_idle;

    look_at_yaw_quaternion uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Floor square root of a 64-bit unsigned value.
    function automatic bit [63:0] floor_root(input bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Division that rounds half away from zero.
    function automatic longint round_div(input longint num, input bit [63:0] den);
        bit [63:0] mag;
        bit [63:0] q;
        if (den == 0)
            return 0;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        q = (mag + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp_one(input longint v);
        if (v > ONE)
            return ONE;
        if (v < -ONE)
            return -ONE;
        return v;
    endfunction

    // Scale a Q30 part by the norm into a saturated Q1.14 value.
    function automatic logic signed [QUAT_W-1:0] part_q14(input longint part,
                                                         input bit [63:0] norm);
        longint v;
        v = (norm != 0) ? round_div(part * 16384, norm) : (part >>> 16);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[QUAT_W-1:0];
    endfunction

    // Camera quaternion for one tracker/target pair.
    function automatic quat_t look_at_quat(input logic [IN_DATA_W-1:0] pos,
                                           input logic valid);
        longint dx, dy, x, y, z, t, sn, cs, s;
        longint part[4];
        bit [63:0] sum, mag, norm;
        bit flip;
        quat_t r;
        dx = longint'($signed(pos[95:64])) - longint'($signed(pos[31:0]));
        dy = longint'($signed(pos[127:96])) - longint'($signed(pos[63:32]));
        sn = 0;
        cs = ONE;
        if (valid && (dx != 0 || dy != 0))
        begin
            // Vectoring pass finds the yaw angle.
            x = dx;
            y = dy;
            z = 0;
            flip = 1'b0;
            if (x < 0)
            begin
                z = (y >= 0) ? PI_V : -PI_V;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < ITERS; i++)
            begin
                if (y < 0)
                begin
                    t = x - (y >>> i); y = y + (x >>> i); x = t;
                    z = z - longint'(ATAN_TAB[i]);
                end
                else
                begin
                    t = x + (y >>> i); y = y - (x >>> i); x = t;
                    z = z + longint'(ATAN_TAB[i]);
                end
            end
            // Fold the angle into a half turn, then rotate for sin and cos.
            if (z > HPI_V)
            begin
                z = z - PI_V;
                flip = 1'b1;
            end
            else if (z < -HPI_V)
            begin
                z = z + PI_V;
                flip = 1'b1;
            end
            x = IGAIN;
            y = 0;
            for (int i = 0; i < ITERS; i++)
            begin
                if (z >= 0)
                begin
                    t = x - (y >>> i); y = y + (x >>> i); x = t;
                    z = z - longint'(ATAN_TAB[i]);
                end
                else
                begin
                    t = x + (y >>> i); y = y - (x >>> i); x = t;
                    z = z + longint'(ATAN_TAB[i]);
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            cs = clamp_one(x);
            sn = clamp_one(y);
        end
        // Trace branch for positive sine, z-dominant branch otherwise.
        if (sn > 0)
        begin
            s = 2 * longint'(floor_root(64'(ONE + sn) << 30));
            part[0] = round_div((-ONE - sn) * ONE, s);
            part[1] = round_div(cs * ONE, s);
            part[2] = round_div(-cs * ONE, s);
            part[3] = s >>> 2;
        end
        else
        begin
            s = 2 * longint'(floor_root(64'(ONE - sn) << 30));
            part[0] = round_div(cs * ONE, s);
            part[1] = round_div((sn - ONE) * ONE, s);
            part[2] = s >>> 2;
            part[3] = round_div(-cs * ONE, s);
        end
        sum = 0;
        for (int k = 0; k < 4; k++)
        begin
            mag = (part[k] < 0) ? 64'(-part[k]) : 64'(part[k]);
            sum = sum + mag * mag;
        end
        norm = floor_root(sum);
        r.x = part_q14(part[0], norm);
        r.y = part_q14(part[1], norm);
        r.z = part_q14(part[2], norm);
        r.w = part_q14(part[3], norm);
        return r;
    endfunction

    // Random gap length: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one item and record its expected quaternion on acceptance.
    task automatic send_pos(input logic [31:0] tx, input logic [31:0] ty,
                            input logic [31:0] gx, input logic [31:0] gy,
                            input logic valid);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {gy, gx, ty, tx};
        s_tuser  <= valid;
        do
            @(posedge clk);
        while (!s_tready);
        quat_expected = {quat_expected, look_at_quat({gy, gx, ty, tx}, valid)};
        items_sent++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Send a relative offset from a given tracker position.
    task automatic send_offset(input logic [31:0] tx, input logic [31:0] ty,
                               input logic [31:0] ox, input logic [31:0] oy,
                               input logic valid);
        send_pos(tx, ty, tx + ox, ty + oy, valid);
    endtask

    // Extremes, special cases and each sector of the plane.
    task automatic test_directed();
        send_pos(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 1'b1);
        send_pos(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1);
        send_pos(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b1);
        send_pos(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1'b1);
        // Invalid target and coincident points give zero yaw.
        send_pos(32'h00010000, 32'h00020000, 32'hFFFF0000, 32'h12345678, 1'b0);
        send_pos(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
        send_pos(32'h12345678, 32'h9ABCDEF0, 32'h12345678, 32'h9ABCDEF0, 1'b1);
        send_pos(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        // Axes and diagonals, including the left half plane on both sides.
        send_offset(32'h0, 32'h0, 32'h00010000, 32'h0, 1'b1);
        send_offset(32'h0, 32'h0, 32'hFFFF0000, 32'h0, 1'b1);
        send_offset(32'h0, 32'h0, 32'h0, 32'h00010000, 1'b1);
        send_offset(32'h0, 32'h0, 32'h0, 32'hFFFF0000, 1'b1);
        send_offset(32'h0, 32'h0, 32'hFFFF0000, 32'h00000001, 1'b1);
        send_offset(32'h0, 32'h0, 32'hFFFF0000, 32'hFFFFFFFF, 1'b1);
        send_offset(32'h0, 32'h0, 32'h00030000, 32'h00030000, 1'b1);
        send_offset(32'h0, 32'h0, 32'hFFFD0000, 32'hFFFD0000, 1'b1);
        send_offset(32'h0, 32'h0, 32'h00030000, 32'hFFFD0000, 1'b1);
        send_offset(32'h0, 32'h0, 32'hFFFD0000, 32'h00030000, 1'b1);
        // Smallest nonzero steps and near-vertical angles.
        send_offset(32'h0, 32'h0, 32'h00000001, 32'h0, 1'b1);
        send_offset(32'h0, 32'h0, 32'h0, 32'hFFFFFFFF, 1'b1);
        send_offset(32'h0, 32'h0, 32'h00000001, 32'h7FFFFFFF, 1'b1);
        send_offset(32'h0, 32'h0, 32'hFFFFFFFF, 32'h80000000, 1'b1);
        send_offset(32'h0, 32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 1'b1);
    endtask

    // Random positions: full-range pairs, nearby targets, invalid targets and coincident points.
    task automatic test_random(input int count);
        logic [31:0] tx, ty, ox, oy;
        int kind;
        for (int n = 0; n < count; n++)
        begin
            no_idle = (n >= count / 3) && (n < count / 3 + 150);
            tx = $urandom;
            ty = $urandom;
            kind = $urandom_range(0, 9);
            if (kind < 4)
                send_pos(tx, ty, $urandom, $urandom, 1'b1);
            else if (kind < 8)
            begin
                // Offsets of random magnitude around the tracker.
                ox = $signed($urandom) >>> $urandom_range(0, 31);
                oy = $signed($urandom) >>> $urandom_range(0, 31);
                send_offset(tx, ty, ox, oy, 1'b1);
            end
            else if (kind < 9)
                send_pos(tx, ty, $urandom, $urandom, 1'b0);
            else
                send_pos(tx, ty, tx, ty, 1'($urandom_range(0, 1)));
        end
        no_idle = 1'b0;
    endtask

    // Receiver side: random stalls on the result stream, none while no_idle is set.
    always @(negedge clk)
    begin
        if (no_idle)
            m_tready <= 1'b1;
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2: m_tready <= 1'b0;
                3:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // Compare each delivered quaternion with the oldest expectation.
    always @(posedge clk)
    begin
        quat_t got;
        quat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            quats_checked++;
            if (quat_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected quaternion %h with nothing pending", m_tdata);
            end
            else
            begin
                want = quat_expected.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Quaternion %0d: expected x=%0d y=%0d z=%0d w=%0d,",
                                  " got x=%0d y=%0d z=%0d w=%0d"},
                                 quats_checked, want.x, want.y, want.z, want.w,
                                 got.x, got.y, got.z, got.w);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog expired with %0d quaternions pending", quat_expected.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        mismatches = 0;
        items_sent = 0;
        quats_checked = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(RAND_ITEMS);
        s_tvalid <= 1'b0;

        // Drain the pipeline, then allow for any stray output.
        while (quat_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Sent %0d position items and checked %0d quaternions,", items_sent,
                 quats_checked);
        $display("covering all plane sectors, invalid and coincident targets.");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
        begin
            $display("%0d mismatches in total", mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lay_pkg.sv
rtl/lay_cordic_cell.sv
rtl/lay_sqrt_cell.sv
rtl/lay_div_cell.sv
rtl/look_at_yaw_quaternion.sv
sim/tb.sv
